@@ src/wphd_pkg.sv @@
`timescale 1ns / 1ps
package wphd_pkg;

    localparam int STEPS = 27;
    localparam int ZSHIFT = 20;
    localparam int NORM_W = 41;
    localparam int NORM_STAGES = 3;
    localparam int XY_W = 44;
    localparam int Z_W = 29;
    localparam int HEAD_W = 17;
    localparam int DIST_W = 21;
    localparam int OUT_W = ((HEAD_W + DIST_W + 7) / 8) * 8;
    localparam int HEAD_LAT = NORM_STAGES + STEPS + 2;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic ax_zero;
        logic ay_zero;
    } quad_t;

    // Arctangent of 2^-idx in degrees, scaled by 2^20 and rounded.
    function automatic logic signed [Z_W-1:0] atan_tab(input int idx);
        case (idx)
            0:       atan_tab = Z_W'(47185920);
            1:       atan_tab = Z_W'(27855475);
            2:       atan_tab = Z_W'(14718068);
            3:       atan_tab = Z_W'(7471121);
            4:       atan_tab = Z_W'(3750058);
            5:       atan_tab = Z_W'(1876857);
            6:       atan_tab = Z_W'(938658);
            7:       atan_tab = Z_W'(469357);
            8:       atan_tab = Z_W'(234682);
            9:       atan_tab = Z_W'(117342);
            10:      atan_tab = Z_W'(58671);
            11:      atan_tab = Z_W'(29335);
            12:      atan_tab = Z_W'(14668);
            13:      atan_tab = Z_W'(7334);
            14:      atan_tab = Z_W'(3667);
            15:      atan_tab = Z_W'(1833);
            16:      atan_tab = Z_W'(917);
            17:      atan_tab = Z_W'(458);
            18:      atan_tab = Z_W'(229);
            19:      atan_tab = Z_W'(115);
            20:      atan_tab = Z_W'(57);
            21:      atan_tab = Z_W'(29);
            22:      atan_tab = Z_W'(14);
            23:      atan_tab = Z_W'(7);
            24:      atan_tab = Z_W'(4);
            25:      atan_tab = Z_W'(2);
            26:      atan_tab = Z_W'(1);
            default: atan_tab = '0;
        endcase
    endfunction

endpackage

@@ src/wphd_cordic.sv @@
`timescale 1ns / 1ps
module wphd_cordic #(
    parameter int COORD_WIDTH = 20,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int LAT = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [COORD_WIDTH:0]          ax,
    input  logic [COORD_WIDTH:0]          ay,
    input  wphd_pkg::quad_t               quad,
    output logic [wphd_pkg::HEAD_W-1:0]   heading
);
    import wphd_pkg::*;

    localparam int PAD = LAT - HEAD_LAT;
    localparam int M_W = ANGLE_FRAC_BITS + 7;
    localparam int H_W = ANGLE_FRAC_BITS + 9;
    localparam int RSH = ZSHIFT - ANGLE_FRAC_BITS;
    localparam int Q_N = NORM_STAGES + STEPS + 1;
    localparam logic signed [Z_W-1:0] Z_RIGHT = Z_W'(90 << ZSHIFT);
    localparam logic [Z_W-1:0] ROUND_ADD = Z_W'(1 << (RSH - 1));
    localparam logic signed [H_W-1:0] H_HALF = H_W'(180 << ANGLE_FRAC_BITS);

    logic [NORM_W-1:0]       nx_reg [NORM_STAGES];
    logic [NORM_W-1:0]       ny_reg [NORM_STAGES];
    logic signed [XY_W-1:0]  x_reg [STEPS];
    logic signed [XY_W-1:0]  y_reg [STEPS];
    logic signed [Z_W-1:0]   z_reg [STEPS];
    quad_t                   q_pipe_reg [Q_N];

    logic signed [Z_W-1:0]   z_last;
    logic signed [Z_W-1:0]   z_clamp;
    logic [Z_W-1:0]          z_sum;
    quad_t                   q_last;
    quad_t                   q_fin;
    logic [M_W-1:0]          m_reg;
    logic signed [H_W-1:0]   h_mag;
    logic signed [H_W-1:0]   h_val;
    logic [HEAD_W-1:0]       head_reg;

    // Leading-zero normalization, two binary shift steps per stage.
    for (genvar s = 0; s < NORM_STAGES; s++)
    begin : g_norm
        localparam int K0 = 32 >> (2 * s);
        localparam int K1 = 32 >> (2 * s + 1);
        logic [NORM_W-1:0] in_x, in_y, mid_x, mid_y, out_x, out_y;
        quad_t             in_q;

        if (s == 0)
        begin : g_first
            assign in_x = NORM_W'(ax);
            assign in_y = NORM_W'(ay);
            assign in_q = quad;
        end
        else
        begin : g_rest
            assign in_x = nx_reg[s-1];
            assign in_y = ny_reg[s-1];
            assign in_q = q_pipe_reg[s-1];
        end

        always_comb
        begin
            mid_x = in_x;
            mid_y = in_y;
            if (((in_x | in_y) >> (NORM_W - K0)) == '0)
            begin
                mid_x = in_x << K0;
                mid_y = in_y << K0;
            end
            out_x = mid_x;
            out_y = mid_y;
            if (((mid_x | mid_y) >> (NORM_W - K1)) == '0)
            begin
                out_x = mid_x << K1;
                out_y = mid_y << K1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nx_reg[s]     <= out_x;
                ny_reg[s]     <= out_y;
                q_pipe_reg[s] <= in_q;
            end
        end
    end

    // One vectoring rotation per stage.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        localparam logic signed [Z_W-1:0] T = atan_tab(i);
        logic signed [XY_W-1:0] in_x, in_y, xs, ys;
        logic signed [Z_W-1:0]  in_z;
        quad_t                  in_q;

        if (i == 0)
        begin : g_first
            assign in_x = XY_W'(nx_reg[NORM_STAGES-1]);
            assign in_y = XY_W'(ny_reg[NORM_STAGES-1]);
            assign in_z = '0;
            assign in_q = q_pipe_reg[NORM_STAGES-1];
        end
        else
        begin : g_rest
            assign in_x = x_reg[i-1];
            assign in_y = y_reg[i-1];
            assign in_z = z_reg[i-1];
            assign in_q = q_pipe_reg[NORM_STAGES+i-1];
        end

        assign xs = in_x >>> i;
        assign ys = in_y >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!in_y[XY_W-1] && (in_y != '0))
                begin
                    x_reg[i] <= in_x + ys;
                    y_reg[i] <= in_y - xs;
                    z_reg[i] <= in_z + T;
                end
                else
                begin
                    x_reg[i] <= in_x - ys;
                    y_reg[i] <= in_y + xs;
                    z_reg[i] <= in_z - T;
                end
                q_pipe_reg[NORM_STAGES+i] <= in_q;
            end
        end
    end

    // Axis cases override the rotation result, then clamp and round.
    always_comb
    begin
        z_last = z_reg[STEPS-1];
        q_last = q_pipe_reg[NORM_STAGES+STEPS-1];
        if (q_last.ay_zero)
            z_clamp = '0;
        else if (q_last.ax_zero)
            z_clamp = Z_RIGHT;
        else if (z_last < 0)
            z_clamp = '0;
        else if (z_last > Z_RIGHT)
            z_clamp = Z_RIGHT;
        else
            z_clamp = z_last;
        z_sum = Z_W'(z_clamp) + ROUND_ADD;
    end

    assign q_fin = q_pipe_reg[Q_N-1];

    always_comb
    begin
        h_mag = q_fin.dx_neg ? (H_HALF - H_W'(m_reg)) : H_W'(m_reg);
        h_val = q_fin.dy_neg ? -h_mag : h_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg           <= M_W'(z_sum >> RSH);
            q_pipe_reg[Q_N-1] <= q_last;
            head_reg        <= HEAD_W'(h_val);
        end
    end

    if (PAD == 0)
    begin : g_nopad
        assign heading = head_reg;
    end
    else
    begin : g_pad
        logic [HEAD_W-1:0] pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= head_reg;
                for (int k = 1; k < PAD; k++)
                    pad_reg[k] <= pad_reg[k-1];
            end
        end

        assign heading = pad_reg[PAD-1];
    end

endmodule

@@ src/wphd_isqrt.sv @@
`timescale 1ns / 1ps
module wphd_isqrt #(
    parameter int COORD_WIDTH = 20,
    parameter int LAT = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [COORD_WIDTH:0]          ax,
    input  logic [COORD_WIDTH:0]          ay,
    output logic [wphd_pkg::DIST_W-1:0]   distance
);
    import wphd_pkg::*;

    localparam int AW = COORD_WIDTH + 1;
    localparam int SW = 2 * AW;
    localparam int TW = SW + 1;
    localparam int RW = AW;
    localparam int PAD = LAT - (RW + 2);

    logic [SW-1:0] a2_reg, b2_reg, sum_reg;
    logic [SW-1:0] rem_reg [RW];
    logic [RW-1:0] root_reg [RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg  <= SW'(ax) * SW'(ax);
            b2_reg  <= SW'(ay) * SW'(ay);
            sum_reg <= a2_reg + b2_reg;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar j = 0; j < RW; j++)
    begin : g_digit
        localparam int B = RW - 1 - j;
        logic [SW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [TW-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = sum_reg;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (TW'(rem_in) >= trial)
                begin
                    rem_reg[j]  <= rem_in - SW'(trial);
                    root_reg[j] <= root_in | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[j]  <= rem_in;
                    root_reg[j] <= root_in;
                end
            end
        end
    end

    if (PAD == 0)
    begin : g_nopad
        assign distance = DIST_W'(root_reg[RW-1]);
    end
    else
    begin : g_pad
        logic [DIST_W-1:0] pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= DIST_W'(root_reg[RW-1]);
                for (int k = 1; k < PAD; k++)
                    pad_reg[k] <= pad_reg[k-1];
            end
        end

        assign distance = pad_reg[PAD-1];
    end

endmodule

@@ src/waypoint_heading_and_distance.sv @@
`timescale 1ns / 1ps
// The delay from an accepted input beat to its output beat is set by the 27-stage vectoring
// chain plus normalization, or for wide coordinates by the square root that resolves one
// bit per stage.
// Throughput: one beat per cycle; the pipeline holds only while the output and skid
// registers are both full.
// Reset: rst_n clears all valid bits and the output and skid flags at once.
module waypoint_heading_and_distance #(
    parameter int COORD_WIDTH = 20,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: heading_deg, distance.
    output logic [wphd_pkg::OUT_W-1:0]            m_axis_tdata
);
    import wphd_pkg::*;

    localparam int AW = COORD_WIDTH + 1;
    localparam int SQRT_LAT = COORD_WIDTH + 3;
    localparam int LAT = (HEAD_LAT > SQRT_LAT) ? HEAD_LAT : SQRT_LAT;
    localparam int DEPTH = LAT + 2;

    logic                          en;
    logic [DEPTH-1:0]              valid_reg;
    logic signed [COORD_WIDTH-1:0] start_x, start_y, end_x, end_y;
    logic signed [AW-1:0]          dx_reg, dy_reg;
    logic [AW-1:0]                 ax_reg, ay_reg;
    quad_t                         quad_reg;
    logic [HEAD_W-1:0]             heading;
    logic [DIST_W-1:0]             distance;
    logic [OUT_W-1:0]              pipe_data;
    logic [OUT_W-1:0]              out_data_reg, skid_data_reg;
    logic                          out_valid_reg, skid_valid_reg;

    assign start_x = s_axis_tdata[COORD_WIDTH-1:0];
    assign start_y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign end_x   = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign end_y   = s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DEPTH-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= AW'(end_x) - AW'(start_x);
            dy_reg   <= AW'(end_y) - AW'(start_y);
            ax_reg   <= dx_reg[AW-1] ? AW'(-dx_reg) : AW'(dx_reg);
            ay_reg   <= dy_reg[AW-1] ? AW'(-dy_reg) : AW'(dy_reg);
            quad_reg <= '{dx_neg:  dx_reg[AW-1],
                          dy_neg:  dy_reg[AW-1],
                          ax_zero: (dx_reg == '0),
                          ay_zero: (dy_reg == '0)};
        end
    end

    wphd_cordic #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .LAT             (LAT)
    ) u_cordic (
        .clk     (clk),
        .en      (en),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .quad    (quad_reg),
        .heading (heading)
    );

    wphd_isqrt #(
        .COORD_WIDTH (COORD_WIDTH),
        .LAT         (LAT)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .distance (distance)
    );

    assign pipe_data = OUT_W'({distance, heading});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (valid_reg[DEPTH-1])
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_valid_reg || m_axis_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (valid_reg[DEPTH-1])
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_data_reg <= pipe_data;
            else
                out_data_reg <= pipe_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ src/wphd_checker.sv @@
`timescale 1ns / 1ps
module wphd_checker #(
    parameter int COORD_WIDTH = 20
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [wphd_pkg::OUT_W-1:0]    m_axis_tdata
);
    import wphd_pkg::*;

    // The output flag is cleared as soon as reset is applied.
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output beat valid while in reset");

    // Input is refused only when the skid register is full, which needs a waiting output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output beat waiting");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // A zero distance comes only from a zero vector, whose heading is zero.
    if (COORD_WIDTH < DIST_W)
    begin : g_zero
        a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && (m_axis_tdata[HEAD_W+DIST_W-1:HEAD_W] == '0)
            |-> (m_axis_tdata[HEAD_W-1:0] == '0))
            else $error("zero distance with nonzero heading");
    end

endmodule

bind waypoint_heading_and_distance wphd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_wphd_checker (.*);

@@ dv/tb_waypoint_heading_and_distance.sv @@
`timescale 1ns / 1ps
module tb_waypoint_heading_and_distance;

    import wphd_pkg::*;

    localparam int CW = 20;
    localparam int IN_W = ((4 * CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER = 60;
    localparam int RANDOM_PER_PHASE = 300;

    localparam longint ATAN_DEG_Q20 [STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [DIST_W-1:0] distance;
    } fix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [IN_W-1:0] pending_pairs [$];
    fix_t expected_fixes [$];
    logic in_fire = 1'b0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    waypoint_heading_and_distance u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic fix_t predict_heading_distance(input logic [IN_W-1:0] beat);
        logic signed [CW-1:0] sx, sy, ex, ey;
        longint dx, dy, ax, ay, x, y, z, xs, ys, m, sq, r, t;
        fix_t res;
        sx = beat[CW-1:0];
        sy = beat[2*CW-1:CW];
        ex = beat[3*CW-1:2*CW];
        ey = beat[4*CW-1:3*CW];
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;

        sq = ax * ax + ay * ay;
        r = 0;
        for (int b = 25; b >= 0; b--)
        begin
            t = r | (64'sd1 <<< b);
            if (t * t <= sq)
            begin
                r = t;
            end
        end

        if (ax == 0 && ay == 0)
        begin
            m = 0;
        end
        else
        begin
            if (ay == 0)
            begin
                z = 0;
            end
            else if (ax == 0)
            begin
                z = 64'sd90 <<< ZSHIFT;
            end
            else
            begin
                while ((ax | ay) < (64'sd1 <<< 40))
                begin
                    ax = ax <<< 1;
                    ay = ay <<< 1;
                end
                x = ax;
                y = ay;
                z = 0;
                for (int i = 0; i < STEPS; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_DEG_Q20[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_DEG_Q20[i];
                    end
                end
                if (z < 0)
                begin
                    z = 0;
                end
                if (z > (64'sd90 <<< ZSHIFT))
                begin
                    z = 64'sd90 <<< ZSHIFT;
                end
            end
            m = (z + (64'sd1 <<< (ZSHIFT - 9))) >>> (ZSHIFT - 8);
            if (dx < 0)
            begin
                m = (64'sd180 <<< 8) - m;
            end
            if (dy < 0)
            begin
                m = -m;
            end
        end
        res.heading = m[HEAD_W-1:0];
        res.distance = r[DIST_W-1:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] make_pair(input int sx, input int sy,
                                                  input int ex, input int ey);
        logic [IN_W-1:0] beat;
        beat = '0;
        beat[CW-1:0] = CW'(sx);
        beat[2*CW-1:CW] = CW'(sy);
        beat[3*CW-1:2*CW] = CW'(ex);
        beat[4*CW-1:3*CW] = CW'(ey);
        return beat;
    endfunction

    function automatic logic [IN_W-1:0] random_pair();
        int sx, sy, ex, ey, d, kind;
        sx = int'($signed(CW'($urandom())));
        sy = int'($signed(CW'($urandom())));
        ex = int'($signed(CW'($urandom())));
        ey = int'($signed(CW'($urandom())));
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            ex = sx + $urandom_range(64) - 32;
            ey = sy + $urandom_range(64) - 32;
        end
        else if (kind < 38)
        begin
            ey = sy;
        end
        else if (kind < 46)
        begin
            ex = sx;
        end
        else if (kind < 58)
        begin
            d = $urandom_range(300000);
            ex = sx + (($urandom_range(1) == 1) ? d : -d);
            ey = sy + (($urandom_range(1) == 1) ? d : -d);
        end
        return make_pair(sx, sy, ex, ey);
    endfunction

    task automatic wait_inputs_drained();
        while (pending_pairs.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_fixes.push_back(predict_heading_distance(s_axis_tdata));
            accepted_count <= accepted_count + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The one long hold-off lets the pipeline fill so that the input stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        fix_t got;
        fix_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.heading = m_axis_tdata[HEAD_W-1:0];
            got.distance = m_axis_tdata[HEAD_W+DIST_W-1:HEAD_W];
            if (expected_fixes.size() == 0)
            begin
                $display("%0t: unexpected output beat, heading %0d, distance %0d",
                         $time, $signed(got.heading), got.distance);
                mismatch_count++;
            end
            else
            begin
                want = expected_fixes.pop_front();
                if (got.heading !== want.heading)
                begin
                    $display("%0t: heading mismatch, expected %0d, actual %0d",
                             $time, $signed(want.heading), $signed(got.heading));
                    mismatch_count++;
                end
                if (got.distance !== want.distance)
                begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want.distance, got.distance);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_waypoint_heading_and_distance failed");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 24;
        recv_idle_pct = 86;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(-524288, 524287, -524288, 524287));
        pending_pairs.push_back(make_pair(-100, 7, 250, 7));
        pending_pairs.push_back(make_pair(250, 7, -100, 7));
        pending_pairs.push_back(make_pair(3, -40, 3, 900));
        pending_pairs.push_back(make_pair(3, 900, 3, -40));
        pending_pairs.push_back(make_pair(-524288, -524288, 524287, 524287));
        pending_pairs.push_back(make_pair(524287, 524287, -524288, -524288));
        pending_pairs.push_back(make_pair(-524288, 524287, 524287, -524288));
        pending_pairs.push_back(make_pair(524287, -524288, -524288, 524287));
        pending_pairs.push_back(make_pair(-524288, 0, 524287, 0));
        pending_pairs.push_back(make_pair(0, 524287, 0, -524288));
        pending_pairs.push_back(make_pair(0, 0, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, -1, 1));
        pending_pairs.push_back(make_pair(0, 0, -1, -1));
        pending_pairs.push_back(make_pair(0, 0, 1, -1));
        pending_pairs.push_back(make_pair(-524288, 0, 524287, 1));
        pending_pairs.push_back(make_pair(524287, 0, -524288, -1));
        pending_pairs.push_back(make_pair(0, -524288, 1, 524287));
        pending_pairs.push_back(make_pair(0, 524287, -1, -524288));
        pending_pairs.push_back(make_pair(10, 20, 13, 24));
        pending_pairs.push_back(make_pair(-7, -7, 0, 0));
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            pending_pairs.push_back(random_pair());
        end
        wait_inputs_drained();

        send_idle_pct = 86;
        recv_idle_pct = 24;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            pending_pairs.push_back(random_pair());
        end
        wait_inputs_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            pending_pairs.push_back(random_pair());
        end
        wait_inputs_drained();

        while (expected_fixes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_waypoint_heading_and_distance passed");
        end
        else
        begin
            $display("tb_waypoint_heading_and_distance failed");
        end
        $finish;
    end

endmodule
